/* rtl/vhs_pkg.sv */
// ----------------------------------------------------------------------------
// Voltage health scorer package
// Shared widths, register indexes, risk codes and the divider lane type.
// ----------------------------------------------------------------------------
package vhs_pkg;

  localparam int VOLT_WIDTH = 24;
  localparam int LIM_W      = 16;
  localparam int SCORE_W    = 15;
  localparam int DEN_W      = VOLT_WIDTH + 26;
  localparam int REM_W      = DEN_W + SCORE_W;
  localparam int SH_W       = $clog2(SCORE_W);
  localparam int SUM_W      = SCORE_W + 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (VOLT_WIDTH > LIM_W) ? VOLT_WIDTH : LIM_W;
  localparam int DIV_FIRST  = 5;
  localparam int NUM_STAGES = DIV_FIRST + SCORE_W + 2;
  localparam int NUM_LANES  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RMS_LIM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_LIM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_LIM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DANGER    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WARNING   = 3'd5;

  localparam logic [1:0] RISK_NORMAL  = 2'd0;
  localparam logic [1:0] RISK_WARNING = 2'd1;
  localparam logic [1:0] RISK_DANGER  = 2'd2;

  localparam logic [SCORE_W-1:0] FULL_SCORE = 15'd25600;
  localparam logic [15:0]        DIV5_RECIP = 16'd52429;

  typedef struct packed {
    logic [DEN_W-1:0]   den;
    logic [REM_W-1:0]   rem;
    logic [SCORE_W-1:0] q;
  } lane_t;

endpackage

/* rtl/vhs_divstep.sv */
// ----------------------------------------------------------------------------
// Restoring division step
// Produces one quotient bit of a lane by a compare and subtract.
// ----------------------------------------------------------------------------
module vhs_divstep (
  input  vhs_pkg::lane_t                lane_i,
  input  logic [vhs_pkg::SH_W-1:0]      bit_idx,
  output vhs_pkg::lane_t                lane_o
);

  logic [vhs_pkg::REM_W-1:0] trial;

  assign trial = vhs_pkg::REM_W'(lane_i.den) << bit_idx;

  always_comb begin
    lane_o = lane_i;
    if (lane_i.rem >= trial) begin
      lane_o.rem         = lane_i.rem - trial;
      lane_o.q[bit_idx]  = 1'b1;
    end
  end

endmodule

/* rtl/voltage_health_scorer.sv */
// ----------------------------------------------------------------------------
// Voltage health scorer
// Scores one measurement set per cycle unless stalled and classifies its risk.
// ----------------------------------------------------------------------------
// The block accepts one measurement set in every cycle unless out_ready stalls
// the pipeline; the depth is set by the fifteen restoring division
// stages, one per quotient bit, that follow five input, multiply and setup
// stages and precede the weighted total and the risk compare.
module voltage_health_scorer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [vhs_pkg::VOLT_WIDTH-1:0]     in_rms_volts,
  input  logic signed [vhs_pkg::VOLT_WIDTH-1:0] in_slope_volts,
  input  logic [vhs_pkg::VOLT_WIDTH-1:0]     in_peak_volts,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [vhs_pkg::SCORE_W-1:0]        out_rms_part_score,
  output logic [vhs_pkg::SCORE_W-1:0]        out_slope_part_score,
  output logic [vhs_pkg::SCORE_W-1:0]        out_peak_part_score,
  output logic [vhs_pkg::SCORE_W-1:0]        out_total_score,
  output logic [1:0]                         out_risk_class,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [vhs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vhs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int VW = vhs_pkg::VOLT_WIDTH;
  localparam int DW = vhs_pkg::DEN_W;
  localparam int SW = vhs_pkg::SCORE_W;
  localparam int NS = vhs_pkg::NUM_STAGES;

  logic [VW-1:0]               nominal_r;
  logic [vhs_pkg::LIM_W-1:0]   rms_lim_r;
  logic [VW-2:0]               slope_lim_r;
  logic [vhs_pkg::LIM_W-1:0]   peak_lim_r;
  logic [SW-1:0]               danger_r;
  logic [SW-1:0]               warning_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nominal_r   <= VW'(58880);
      rms_lim_r   <= 16'd6554;
      slope_lim_r <= (VW-1)'(2560);
      peak_lim_r  <= 16'd13107;
      danger_r    <= 15'd15360;
      warning_r   <= 15'd20480;
    end else if (cfg_valid) begin
      case (cfg_index)
        vhs_pkg::REG_NOMINAL:   nominal_r   <= cfg_data[VW-1:0];
        vhs_pkg::REG_RMS_LIM:   rms_lim_r   <= cfg_data[vhs_pkg::LIM_W-1:0];
        vhs_pkg::REG_SLOPE_LIM: slope_lim_r <= cfg_data[VW-2:0];
        vhs_pkg::REG_PEAK_LIM:  peak_lim_r  <= cfg_data[vhs_pkg::LIM_W-1:0];
        vhs_pkg::REG_DANGER:    danger_r    <= cfg_data[SW-1:0];
        vhs_pkg::REG_WARNING:   warning_r   <= cfg_data[SW-1:0];
        default: ;
      endcase
    end
  end

  logic [NS-1:0] valid_r;
  logic [NS:0]   ready;

  assign in_ready  = ready[0];
  assign out_valid = valid_r[NS-1];

  always_comb begin
    ready[NS] = out_ready;
    for (int k = 0; k < NS; k++) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (ready[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (ready[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  logic [VW-1:0] a_rms_r, a_slope_r, a_peak_r;

  always_ff @(posedge clk) begin
    if (ready[0]) begin
      a_rms_r   <= in_rms_volts;
      a_slope_r <= in_slope_volts;
      a_peak_r  <= in_peak_volts;
    end
  end

  logic [VW-1:0]    b_dr_r, b_mag_r;
  logic [VW+15:0]   b_nl_r;
  logic [VW+9:0]    b_e707_r;
  logic [VW+7:0]    b_a250_r;
  logic             b_rzero_r;

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      b_dr_r    <= (a_rms_r >= nominal_r) ? a_rms_r - nominal_r : nominal_r - a_rms_r;
      b_mag_r   <= a_slope_r[VW-1] ? VW'(0) - a_slope_r : a_slope_r;
      b_nl_r    <= (VW+16)'(nominal_r) * (VW+16)'(rms_lim_r);
      b_e707_r  <= (VW+10)'(a_rms_r) * (VW+10)'(707);
      b_a250_r  <= (VW+8)'(a_peak_r) * (VW+8)'(250);
      b_rzero_r <= (a_rms_r == '0);
    end
  end

  logic [DW-1:0] c_den_r [vhs_pkg::NUM_LANES];
  logic [DW-1:0] c_err_r [vhs_pkg::NUM_LANES];
  logic          c_rzero_r;
  logic [VW+9:0] pk_diff;

  assign pk_diff = ((VW+10)'(b_a250_r) >= b_e707_r) ? (VW+10)'(b_a250_r) - b_e707_r
                                                    : b_e707_r - (VW+10)'(b_a250_r);

  always_ff @(posedge clk) begin
    if (ready[2]) begin
      c_den_r[0] <= DW'(b_nl_r);
      c_err_r[0] <= DW'(b_dr_r) << 16;
      c_den_r[1] <= DW'(slope_lim_r);
      c_err_r[1] <= DW'(b_mag_r);
      c_den_r[2] <= DW'(b_e707_r) * DW'(peak_lim_r);
      c_err_r[2] <= DW'(pk_diff) << 16;
      c_rzero_r  <= b_rzero_r;
    end
  end

  logic [DW-1:0] d_x_r   [vhs_pkg::NUM_LANES];
  logic [DW-1:0] d_den_r [vhs_pkg::NUM_LANES];
  logic          d_ok_r  [vhs_pkg::NUM_LANES];

  always_ff @(posedge clk) begin
    if (ready[3]) begin
      for (int l = 0; l < vhs_pkg::NUM_LANES; l++) begin
        d_x_r[l]   <= c_den_r[l] - c_err_r[l];
        d_den_r[l] <= c_den_r[l];
        d_ok_r[l]  <= (c_den_r[l] != '0) && (c_err_r[l] < c_den_r[l]) &&
                      !((l == 2) && c_rzero_r);
      end
    end
  end

  vhs_pkg::lane_t div_r   [SW+1][vhs_pkg::NUM_LANES];
  vhs_pkg::lane_t div_nxt [SW][vhs_pkg::NUM_LANES];

  always_ff @(posedge clk) begin
    if (ready[4]) begin
      for (int l = 0; l < vhs_pkg::NUM_LANES; l++) begin
        div_r[0][l].q <= '0;
        if (d_ok_r[l]) begin
          div_r[0][l].den <= d_den_r[l];
          div_r[0][l].rem <= ((vhs_pkg::REM_W'(d_x_r[l]) << 6) +
                              (vhs_pkg::REM_W'(d_x_r[l]) << 5) +
                              (vhs_pkg::REM_W'(d_x_r[l]) << 2)) << 8;
        end else begin
          div_r[0][l].den <= DW'(1);
          div_r[0][l].rem <= '0;
        end
      end
    end
  end

  for (genvar g = 0; g < SW; g++) begin : g_div
    for (genvar l = 0; l < vhs_pkg::NUM_LANES; l++) begin : g_lane
      vhs_divstep u_step (
        .lane_i  (div_r[g][l]),
        .bit_idx (vhs_pkg::SH_W'(SW - 1 - g)),
        .lane_o  (div_nxt[g][l])
      );
    end

    always_ff @(posedge clk) begin
      if (ready[vhs_pkg::DIV_FIRST + g]) begin
        div_r[g+1] <= div_nxt[g];
      end
    end
  end

  logic [SW-1:0]            t_q_r [vhs_pkg::NUM_LANES];
  logic [SW-1:0]            t_total_r;
  logic [vhs_pkg::SUM_W-1:0] wsum;
  logic [vhs_pkg::SUM_W+15:0] wprod;

  assign wsum  = (vhs_pkg::SUM_W'(div_r[SW][0].q) << 1) +
                 (vhs_pkg::SUM_W'(div_r[SW][1].q) << 1) +
                 vhs_pkg::SUM_W'(div_r[SW][2].q);
  assign wprod = (vhs_pkg::SUM_W+16)'(wsum) * (vhs_pkg::SUM_W+16)'(vhs_pkg::DIV5_RECIP);

  always_ff @(posedge clk) begin
    if (ready[NS-2]) begin
      for (int l = 0; l < vhs_pkg::NUM_LANES; l++) begin
        t_q_r[l] <= div_r[SW][l].q;
      end
      t_total_r <= wprod[SW+17:18];
    end
  end

  always_ff @(posedge clk) begin
    if (ready[NS-1]) begin
      out_rms_part_score   <= t_q_r[0];
      out_slope_part_score <= t_q_r[1];
      out_peak_part_score  <= t_q_r[2];
      out_total_score      <= t_total_r;
      if (t_total_r < danger_r) begin
        out_risk_class <= vhs_pkg::RISK_DANGER;
      end else if (t_total_r < warning_r) begin
        out_risk_class <= vhs_pkg::RISK_WARNING;
      end else begin
        out_risk_class <= vhs_pkg::RISK_NORMAL;
      end
    end
  end

endmodule

/* rtl/vhs_checker.sv */
// ----------------------------------------------------------------------------
// Voltage health scorer checker
// Port level properties of the scorer, bound to the top level.
// ----------------------------------------------------------------------------
module vhs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [vhs_pkg::SCORE_W-1:0]  out_rms_part_score,
  input logic [vhs_pkg::SCORE_W-1:0]  out_total_score,
  input logic [1:0]                   out_risk_class
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_total_score))
    else $error("result dropped or changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  a_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_total_score <= vhs_pkg::FULL_SCORE &&
                  out_rms_part_score <= vhs_pkg::FULL_SCORE)
    else $error("score above full scale");

  a_risk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_risk_class == vhs_pkg::RISK_NORMAL ||
                  out_risk_class == vhs_pkg::RISK_WARNING ||
                  out_risk_class == vhs_pkg::RISK_DANGER)
    else $error("invalid risk class");

endmodule

bind voltage_health_scorer vhs_checker u_vhs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_rms_part_score (out_rms_part_score),
  .out_total_score    (out_total_score),
  .out_risk_class     (out_risk_class)
);
